@@ sv/lz_window_decompressor_macros.svh @@
// Assertion helpers shared by the decoder modules.
`ifndef LZ_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZ_WINDOW_DECOMPRESSOR_MACROS_SVH

// Plain implication checked on every rising clock edge outside reset.
`define LZD_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Condition in one cycle implies a condition in the next.
`define LZD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ sv/lzd_pkg.sv @@
package lzd_pkg;

   localparam int WINDOW_DEPTH_DEF     = 4096;
   localparam int BYTES_PER_RESULT_DEF = 8;
   localparam int COUNT_WIDTH_DEF      = 32;
   localparam int EXP_WIDTH            = 31;
   localparam int BYTE_WIDTH           = 8;
   localparam int OFFSET_WIDTH         = 12;
   localparam int LEN_WIDTH            = 9;

   localparam logic [7:0] SHORT_TOKEN_MIN = 8'h60;
   localparam logic [3:0] LEN_CODE_LONG   = 4'd5;

   typedef enum logic [2:0] {
      PH_FLAG,
      PH_ITEM,
      PH_OFFLO,
      PH_SUPER,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_PARSE,
      ST_READ,
      ST_COPY,
      ST_OUT
   } ctrl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear;       // start of stream: clear counters
      logic lit;         // store the literal byte and stage a result
      logic copy_start;  // load copy offset and length
      logic copy_step;   // move one byte of a copy
      logic stage_copy;  // close a group of copy bytes into the output slot
      logic stage_end;   // stage the end-of-stream result
      logic out_last;    // staged result is the last for the input byte
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic copy_done;   // copy length exhausted
      logic group_full;  // current group holds a full set of bytes
      logic out_full;    // output slot is occupied
   } dp_status_type;

endpackage

@@ sv/lzd_ram.sv @@
module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lzd_datapath.sv @@
`include "lz_window_decompressor_macros.svh"

module lzd_datapath import lzd_pkg::*; #(
   parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
   parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF,
   parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dp_cmd_type                             cmd,
   output dp_status_type                          status,
   input  logic [BYTE_WIDTH-1:0]                  lit_byte,
   input  logic [OFFSET_WIDTH-1:0]                copy_offset,
   input  logic [LEN_WIDTH-1:0]                   copy_len,
   input  logic [EXP_WIDTH-1:0]                   expected_length,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [BYTES_PER_RESULT*BYTE_WIDTH-1:0] rsp_out_bytes,
   output logic [$clog2(BYTES_PER_RESULT+1)-1:0]  rsp_byte_count,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_stream_end,
   output logic                                   rsp_history_error,
   output logic                                   rsp_length_mismatch,
   output logic [COUNT_WIDTH-1:0]                 rsp_total_length
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int GW = $clog2(BYTES_PER_RESULT+1);
   localparam int GI = $clog2(BYTES_PER_RESULT);
   localparam int DW = BYTES_PER_RESULT*BYTE_WIDTH;

   logic [AW-1:0]          wptr_ff, wptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   err_ff, err_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic [DW-1:0]          grp_ff, grp_in;
   logic [GW-1:0]          gcnt_ff, gcnt_in;

   logic                   ov_ff, ov_in;
   logic [DW-1:0]          obytes_ff, obytes_in;
   logic [GW-1:0]          ocnt_ff, ocnt_in;
   logic                   olast_ff, olast_in;
   logic                   oend_ff, oend_in;
   logic                   oerr_ff, oerr_in;
   logic                   omm_ff, omm_in;
   logic [COUNT_WIDTH-1:0] otot_ff, otot_in;

   logic                   wr_en;
   logic [BYTE_WIDTH-1:0]  wr_data;
   logic [AW-1:0]          rd_addr;
   logic [BYTE_WIDTH-1:0]  rd_data;
   logic                   before_start;
   logic                   cnt_sat;
   logic [COUNT_WIDTH-1:0] count_base;
   logic [AW-1:0]          wptr_base;
   logic                   err_base;

   lzd_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read address is taken from the next write pointer and offset. An
   // overlapping copy with offset one reads the entry written in the same cycle,
   // so that case is forwarded from the byte just written.
   logic                  fwd_ff;
   logic [BYTE_WIDTH-1:0] fwd_data_ff;
   logic [BYTE_WIDTH-1:0] rd_byte;

   assign rd_addr = AW'(wptr_in - AW'(off_in));
   assign rd_byte = fwd_ff ? fwd_data_ff : rd_data;

   assign before_start = (COUNT_WIDTH'(off_ff) > count_ff);
   assign cnt_sat      = &count_ff;

   always_comb begin
      count_base = cmd.clear ? '0 : count_ff;
      wptr_base  = cmd.clear ? '0 : wptr_ff;
      err_base   = cmd.clear ? 1'b0 : err_ff;
      wptr_in    = wptr_base;
      count_in   = count_base;
      err_in     = err_base;
      off_in     = off_ff;
      len_in     = len_ff;
      grp_in     = grp_ff;
      gcnt_in    = gcnt_ff;
      wr_en      = 1'b0;
      wr_data    = lit_byte;
      if (cmd.lit) begin
         wr_en    = 1'b1;
         wptr_in  = wptr_ff + 1'b1;
         count_in = cnt_sat ? count_ff : count_ff + 1'b1;
      end
      if (cmd.copy_start) begin
         off_in  = copy_offset;
         len_in  = copy_len;
         grp_in  = '0;
         gcnt_in = '0;
      end
      if (cmd.copy_step) begin
         wr_en   = 1'b1;
         wr_data = before_start ? '0 : rd_byte;
         if (before_start) begin
            err_in = 1'b1;
         end
         wptr_in  = wptr_ff + 1'b1;
         count_in = cnt_sat ? count_ff : count_ff + 1'b1;
         len_in   = len_ff - 1'b1;
         grp_in[BYTE_WIDTH*gcnt_ff[GI-1:0] +: BYTE_WIDTH] = wr_data;
         gcnt_in  = gcnt_ff + 1'b1;
      end
      if (cmd.stage_copy) begin
         grp_in  = '0;
         gcnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         count_ff <= '0;
         err_ff   <= 1'b0;
         len_ff   <= '0;
         gcnt_ff  <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         wptr_ff  <= wptr_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         len_ff   <= len_in;
         gcnt_ff  <= gcnt_in;
         fwd_ff   <= wr_en && (off_in == OFFSET_WIDTH'(1));
      end
      off_ff      <= off_in;
      grp_ff      <= grp_in;
      fwd_data_ff <= wr_data;
   end

   assign status.copy_done  = (len_ff == '0);
   assign status.group_full = (gcnt_ff == GW'(BYTES_PER_RESULT));
   assign status.out_full   = ov_ff;

   always_comb begin
      ov_in     = ov_ff && !rsp_ready;
      obytes_in = obytes_ff;
      ocnt_in   = ocnt_ff;
      olast_in  = olast_ff;
      oend_in   = oend_ff;
      oerr_in   = oerr_ff;
      omm_in    = omm_ff;
      otot_in   = otot_ff;
      if (cmd.lit || cmd.stage_copy || cmd.stage_end) begin
         ov_in    = 1'b1;
         olast_in = cmd.out_last;
         oerr_in  = err_in;
         otot_in  = count_in;
         oend_in  = cmd.stage_end;
         omm_in   = cmd.stage_end &&
                    (count_base != COUNT_WIDTH'(expected_length));
         if (cmd.lit) begin
            obytes_in = DW'(lit_byte);
            ocnt_in   = GW'(1);
         end else if (cmd.stage_copy) begin
            obytes_in = grp_ff;
            ocnt_in   = gcnt_ff;
         end else begin
            obytes_in = '0;
            ocnt_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
      obytes_ff <= obytes_in;
      ocnt_ff   <= ocnt_in;
      olast_ff  <= olast_in;
      oend_ff   <= oend_in;
      oerr_ff   <= oerr_in;
      omm_ff    <= omm_in;
      otot_ff   <= otot_in;
   end

   assign rsp_valid           = ov_ff;
   assign rsp_out_bytes       = obytes_ff;
   assign rsp_byte_count      = ocnt_ff;
   assign rsp_last_of_run     = olast_ff;
   assign rsp_stream_end      = oend_ff;
   assign rsp_history_error   = oerr_ff;
   assign rsp_length_mismatch = omm_ff;
   assign rsp_total_length    = otot_ff;

   `LZD_ASSERT_IMPL(a_no_overwrite, clock, reset,
      ov_ff && !rsp_ready, !(cmd.lit || cmd.stage_copy || cmd.stage_end),
      "output slot overwritten while a transaction is pending")
   `LZD_ASSERT_IMPL(a_group_bound, clock, reset,
      1'b1, gcnt_ff <= GW'(BYTES_PER_RESULT), "copy group overflow")
   `LZD_ASSERT_NEXT(a_err_sticky, clock, reset,
      err_ff && !cmd.clear, err_ff, "history error cleared without a new stream")

endmodule

@@ sv/lzd_ctrl.sv @@
`include "lz_window_decompressor_macros.svh"

module lzd_ctrl import lzd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [BYTE_WIDTH-1:0]   req_in_byte,
   input  logic                    req_first_byte,
   output dp_cmd_type              cmd,
   input  dp_status_type           status,
   output logic [OFFSET_WIDTH-1:0] copy_offset,
   output logic [LEN_WIDTH-1:0]    copy_len
);

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [7:0]     tags_ff, tags_in;
   logic [3:0]     left_ff, left_in;
   logic [7:0]     tok_ff, tok_in;
   logic [OFFSET_WIDTH-1:0] poff_ff, poff_in;

   logic       accept;
   phase_type  ph;
   logic [7:0] tags_cur;
   logic [3:0] left_cur;
   logic [OFFSET_WIDTH-1:0] off_lo;
   logic [3:0] code;
   logic       start_copy;
   logic       do_lit;
   logic       do_end;
   logic       item_done;

   assign accept   = req_valid && req_ready;
   assign ph       = req_first_byte ? PH_FLAG : phase_ff;
   assign tags_cur = req_first_byte ? 8'd0 : tags_ff;
   assign left_cur = req_first_byte ? 4'd0 : left_ff;
   assign off_lo   = {tok_ff[3:0], req_in_byte};
   assign code     = tok_ff[7:4];

   // Decode of the accepted byte.
   always_comb begin
      phase_in    = phase_ff;
      tags_in     = tags_ff;
      left_in     = left_ff;
      tok_in      = req_first_byte ? 8'd0 : tok_ff;
      poff_in     = req_first_byte ? '0 : poff_ff;
      start_copy  = 1'b0;
      do_lit      = 1'b0;
      do_end      = 1'b0;
      item_done   = 1'b0;
      copy_offset = off_lo;
      copy_len    = LEN_WIDTH'(code) + LEN_WIDTH'(3);
      case (ph)
         PH_FLAG: begin
            tags_in  = req_in_byte;
            left_in  = 4'd8;
            phase_in = PH_ITEM;
         end
         PH_ITEM: begin
            tags_in = tags_cur;
            left_in = left_cur;
            if (!tags_cur[0]) begin
               do_lit    = 1'b1;
               item_done = 1'b1;
            end else if (req_in_byte >= SHORT_TOKEN_MIN) begin
               start_copy  = 1'b1;
               item_done   = 1'b1;
               copy_offset = OFFSET_WIDTH'(9'h100 - {1'b0, req_in_byte});
               copy_len    = LEN_WIDTH'(2);
            end else begin
               tok_in   = req_in_byte;
               phase_in = PH_OFFLO;
            end
         end
         PH_OFFLO: begin
            if (off_lo == '0) begin
               do_end   = 1'b1;
               phase_in = PH_DONE;
            end else if (code != LEN_CODE_LONG) begin
               start_copy = 1'b1;
               item_done  = 1'b1;
            end else begin
               poff_in  = off_lo;
               phase_in = PH_SUPER;
            end
         end
         PH_SUPER: begin
            start_copy  = 1'b1;
            item_done   = 1'b1;
            copy_offset = poff_ff;
            copy_len    = LEN_WIDTH'(8) + LEN_WIDTH'(req_in_byte);
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      if (item_done) begin
         tags_in  = {1'b0, tags_cur[7:1]};
         left_in  = (left_cur != 4'd0) ? left_cur - 4'd1 : 4'd0;
         phase_in = (left_in != 4'd0) ? PH_ITEM : PH_FLAG;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_PARSE: begin
            if (accept && start_copy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (status.copy_done || status.group_full) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_full) begin
               state_in = status.copy_done ? ST_PARSE : ST_COPY;
            end
         end
         default: begin
            state_in = ST_PARSE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_PARSE: begin
            req_ready      = !status.out_full;
            cmd.clear      = accept && req_first_byte;
            cmd.lit        = accept && do_lit;
            cmd.stage_end  = accept && do_end;
            cmd.copy_start = accept && start_copy;
            cmd.out_last   = 1'b1;
         end
         ST_COPY: begin
            cmd.copy_step = !status.copy_done && !status.group_full;
         end
         ST_OUT: begin
            cmd.stage_copy = !status.out_full;
            cmd.out_last   = status.copy_done;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PARSE;
         phase_ff <= PH_FLAG;
         tags_ff  <= '0;
         left_ff  <= '0;
         tok_ff   <= '0;
         poff_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            phase_ff <= phase_in;
            tags_ff  <= tags_in;
            left_ff  <= left_in;
            tok_ff   <= tok_in;
            poff_ff  <= poff_in;
         end
      end
   end

   `LZD_ASSERT_IMPL(a_ready_parse, clock, reset,
      req_ready, state_ff == ST_PARSE, "input taken while a copy runs")
   `LZD_ASSERT_NEXT(a_copy_enter, clock, reset,
      accept && start_copy, state_ff == ST_READ, "copy did not start")
   `LZD_ASSERT_IMPL(a_one_cmd, clock, reset,
      1'b1, $countones({cmd.lit, cmd.stage_copy, cmd.stage_end}) <= 1,
      "two results staged at once")

endmodule

@@ sv/lz_window_decompressor.sv @@
// A literal or end marker shows on the result port in the cycle after it is accepted.
// A copy of N bytes in G = ceil(N/BYTES_PER_RESULT) groups starts with a read state, then
// moves one byte a cycle within a group through the single read port of the window memory,
// with a check and a staging step per group; staging waits while the output slot is full;
// the next byte waits till the copy ends and its last transaction has left. Synchronous
// active-high reset clears parser, counts, error flag, result valid and expected length.
module lz_window_decompressor import lzd_pkg::*; #(
   parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
   parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF,
   parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [EXP_WIDTH-1:0]                   csr_expected_length,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [BYTE_WIDTH-1:0]                  req_in_byte,
   input  logic                                   req_first_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [BYTES_PER_RESULT*BYTE_WIDTH-1:0] rsp_out_bytes,
   output logic [$clog2(BYTES_PER_RESULT+1)-1:0]  rsp_byte_count,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_stream_end,
   output logic                                   rsp_history_error,
   output logic                                   rsp_length_mismatch,
   output logic [COUNT_WIDTH-1:0]                 rsp_total_length
);

   logic [EXP_WIDTH-1:0]    exp_len_ff;
   dp_cmd_type              cmd;
   dp_status_type           status;
   logic [OFFSET_WIDTH-1:0] copy_offset;
   logic [LEN_WIDTH-1:0]    copy_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= '0;
      end else if (csr_write_enable) begin
         exp_len_ff <= csr_expected_length;
      end
   end

   lzd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .cmd            (cmd),
      .status         (status),
      .copy_offset    (copy_offset),
      .copy_len       (copy_len)
   );

   lzd_datapath #(
      .WINDOW_DEPTH     (WINDOW_DEPTH),
      .BYTES_PER_RESULT (BYTES_PER_RESULT),
      .COUNT_WIDTH      (COUNT_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .lit_byte            (req_in_byte),
      .copy_offset         (copy_offset),
      .copy_len            (copy_len),
      .expected_length     (exp_len_ff),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_out_bytes       (rsp_out_bytes),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_stream_end      (rsp_stream_end),
      .rsp_history_error   (rsp_history_error),
      .rsp_length_mismatch (rsp_length_mismatch),
      .rsp_total_length    (rsp_total_length)
   );

endmodule
